// ----- hw/rtl/prefix_code_text_encoder_macros.svh -----
// Assertion macros for the prefix code text encoder checker.
// Needs aclk and aresetn in the scope of the use.
`ifndef PREFIX_CODE_TEXT_ENCODER_MACROS_SVH
`define PREFIX_CODE_TEXT_ENCODER_MACROS_SVH

// check a consequence in the cycle after the antecedent, skipped while in reset
`define PCT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("pct check failed");

// check a consequence in the cycle after the antecedent, reset included
`define PCT_ASSERT_NEXT_ALWAYS(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("pct check failed");

`endif

// ----- hw/rtl/pct_pkg.sv -----
// Shared types, constants and code table of the prefix code text encoder.
// Used by pct_packer and prefix_code_text_encoder.
package pct_pkg;

    localparam int SymW    = 8;
    localparam int ByteW   = 8;
    localparam int CodeW   = 13;
    localparam int LenW    = 5;
    localparam int PendW   = 7;
    localparam int PcntW   = 3;
    localparam int StreamW = PendW + 20;
    localparam int QDepth  = 4;
    localparam int QIdxW   = 2;
    localparam int QCntW   = 3;

    localparam logic [CodeW-1:0] TermCode = 13'd8190;
    localparam logic [LenW-1:0]  TermLen  = 5'd13;
    localparam logic             ModeChar  = 1'b0;
    localparam logic             ModeFlush = 1'b1;

    typedef struct packed {
        logic [CodeW-1:0] code_left;
        logic [LenW-1:0]  len;
    } code_t;

    typedef struct packed {
        logic             last;
        logic [ByteW-1:0] data;
    } word_t;

    typedef struct packed {
        logic [1:0]       count;
        word_t [2:0]      words;
        logic [PendW-1:0] pend;
        logic [PcntW-1:0] pend_cnt;
    } pack_t;

    function automatic code_t lookup_code(input logic [SymW-1:0] sym);
        logic [4:0] rank;
        logic       hit;
        logic [4:0] off5;
        logic [2:0] off;
        code_t      res;
        hit  = 1'b1;
        rank = 5'd0;
        unique case (sym)
            8'h65: rank = 5'd0;
            8'h74: rank = 5'd1;
            8'h61: rank = 5'd2;
            8'h6f: rank = 5'd3;
            8'h6e: rank = 5'd4;
            8'h73: rank = 5'd5;
            8'h68: rank = 5'd6;
            8'h72: rank = 5'd7;
            8'h64: rank = 5'd8;
            8'h6c: rank = 5'd9;
            8'h69: rank = 5'd10;
            8'h63: rank = 5'd11;
            8'h75: rank = 5'd12;
            8'h6d: rank = 5'd13;
            8'h77: rank = 5'd14;
            8'h66: rank = 5'd15;
            8'h67: rank = 5'd16;
            8'h79: rank = 5'd17;
            8'h70: rank = 5'd18;
            8'h62: rank = 5'd19;
            8'h76: rank = 5'd20;
            8'h6b: rank = 5'd21;
            8'h6a: rank = 5'd22;
            8'h78: rank = 5'd23;
            8'h71: rank = 5'd24;
            8'h7a: rank = 5'd25;
            default: hit = 1'b0;
        endcase
        if (!hit) begin
            res.code_left = '0;
            res.len       = 5'd1;
        end else if (rank < 5'd7) begin
            off5          = rank;
            off           = off5[2:0];
            res.code_left = {1'b1, off, 9'b0};
            res.len       = 5'd4;
        end else if (rank < 5'd14) begin
            off5          = rank - 5'd7;
            off           = off5[2:0];
            res.code_left = {4'hf, off, 6'b0};
            res.len       = 5'd7;
        end else if (rank < 5'd21) begin
            off5          = rank - 5'd14;
            off           = off5[2:0];
            res.code_left = {7'h7f, off, 3'b0};
            res.len       = 5'd10;
        end else begin
            off5          = rank - 5'd21;
            off           = off5[2:0];
            res.code_left = {10'h3ff, off};
            res.len       = 5'd13;
        end
        return res;
    endfunction

endpackage

// ----- hw/rtl/pct_packer.sv -----
// Code lookup and MSB-first byte packing for one input word.
// Depends on pct_pkg.
module pct_packer (
    input  logic                      mode,
    input  logic [pct_pkg::SymW-1:0]  symbol,
    input  logic [pct_pkg::PendW-1:0] pend_bits,
    input  logic [pct_pkg::PcntW-1:0] pend_cnt,
    output pct_pkg::pack_t            pack
);
    import pct_pkg::*;

    code_t              code;
    logic [StreamW-1:0] stream;
    logic [LenW-1:0]    total;
    logic [1:0]         nfull;
    logic [ByteW-1:0]   b0, b1, b2, remb;

    always_comb begin
        if (mode == ModeFlush) begin
            code.code_left = TermCode;
            code.len       = TermLen;
        end else begin
            code = lookup_code(symbol);
        end
        stream = {pend_bits, 20'b0} | ({code.code_left, 14'b0} >> pend_cnt);
        total  = {2'b0, pend_cnt} + code.len;
        nfull  = total[4:3];
        b0     = stream[26:19];
        b1     = stream[18:11];
        b2     = stream[10:3];
        unique case (nfull)
            2'd0:    remb = b0;
            2'd1:    remb = b1;
            default: remb = b2;
        endcase
        pack.words[0] = {1'b0, b0};
        pack.words[1] = {1'b0, b1};
        pack.words[2] = {1'b0, b2};
        if (mode == ModeFlush) begin
            pack.count    = nfull + 2'd1;
            pack.words[nfull].last = 1'b1;
            pack.pend     = '0;
            pack.pend_cnt = '0;
        end else begin
            pack.count    = nfull;
            pack.pend     = remb[7:1];
            pack.pend_cnt = total[2:0];
        end
    end

endmodule

// ----- hw/rtl/prefix_code_text_encoder.sv -----
// Prefix code text encoder: symbol stream in, packed byte stream out.
// Depends on pct_pkg and pct_packer.
//
// Input words carry one ASCII symbol in s_tdata and the mode in s_tuser:
// mode 0 encodes the symbol, mode 1 ends the message. Space and any byte
// outside a..z take the one-bit code 0; letters take 4 to 13 bits.
// Output words are packed bytes, MSB first; m_tlast marks the final
// zero-padded byte of a message, which always follows end of message.
// A character gives 0 to 2 bytes, end of message 2 or 3 bytes.
// When the queue is empty, the first byte of a word shows on m_tvalid in the
// cycle after the word is taken. The output side moves one byte per cycle
// while m_tready is high. The byte queue holds four entries; s_tready is
// high while at most one byte waits, so a word is taken in every cycle as
// long as each word yields at most one byte and the receiver does not
// stall; otherwise the input waits while the output side drains the queue.
// When the receiver stalls, the head byte holds and the queue fills until
// s_tready falls. Reset empties the queue and clears the pending bits,
// so the next symbol starts a byte-aligned message.
module prefix_code_text_encoder (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [pct_pkg::SymW-1:0]  s_tdata,   // [7:0] symbol
    input  logic [0:0]                s_tuser,   // [0] mode
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [pct_pkg::ByteW-1:0] m_tdata,   // [7:0] out_byte
    output logic                      m_tlast
);
    import pct_pkg::*;

    word_t [QDepth-1:0] q_reg, q_next;
    logic [QCntW-1:0]   cnt_reg, cnt_next;
    logic [PendW-1:0]   pend_reg;
    logic [PcntW-1:0]   pcnt_reg;
    pack_t              pk;
    logic               accept, pop;
    logic [QCntW-1:0]   base, push_n, rel;

    pct_packer u_packer (
        .mode      (s_tuser[0]),
        .symbol    (s_tdata),
        .pend_bits (pend_reg),
        .pend_cnt  (pcnt_reg),
        .pack      (pk)
    );

    assign s_tready = (cnt_reg < 3'd2);
    assign m_tvalid = (cnt_reg != '0);
    assign m_tdata  = q_reg[0].data;
    assign m_tlast  = q_reg[0].last;
    assign accept   = s_tvalid & s_tready;
    assign pop      = m_tvalid & m_tready;

    always_comb begin
        base     = cnt_reg - QCntW'(pop);
        push_n   = accept ? {1'b0, pk.count} : '0;
        cnt_next = base + push_n;
        rel      = '0;
        for (int i = 0; i < QDepth; i++) begin
            if (pop && i < QDepth - 1) begin
                q_next[i] = q_reg[i+1];
            end else begin
                q_next[i] = q_reg[i];
            end
            rel = QCntW'(i) - base;
            if (accept && QCntW'(i) >= base && rel < push_n) begin
                q_next[i] = pk.words[rel[1:0]];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            pend_reg <= '0;
            pcnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
            if (accept) begin
                pend_reg <= pk.pend;
                pcnt_reg <= pk.pend_cnt;
            end
        end
    end

    always_ff @(posedge aclk) begin
        q_reg <= q_next;
    end

endmodule

// ----- hw/rtl/pct_checker.sv -----
// Port-level checks for the prefix code text encoder, bound to the top level.
// Depends on prefix_code_text_encoder_macros.svh.
`include "prefix_code_text_encoder_macros.svh"

module pct_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [7:0] s_tdata,
    input logic [0:0] s_tuser,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);

    `PCT_ASSERT_NEXT_ALWAYS(a_reset_empty, !aresetn, !m_tvalid)
    `PCT_ASSERT_NEXT(a_stall_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    `PCT_ASSERT_NEXT(a_flush_out, s_tvalid && s_tready && s_tuser[0], m_tvalid && !s_tready)
    `PCT_ASSERT_NEXT(a_ready_idle, !m_tvalid && !(s_tvalid && s_tready), s_tready)

endmodule

bind prefix_code_text_encoder pct_checker u_pct_checker (.*);
